/* rtl/core/smeu_pkg.sv */
package smeu_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int SP_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic [4:0] OP_PUSH = 5'd0;
   localparam logic [4:0] OP_ADD = 5'd1;
   localparam logic [4:0] OP_SUB = 5'd2;
   localparam logic [4:0] OP_MUL = 5'd3;
   localparam logic [4:0] OP_DIV = 5'd4;
   localparam logic [4:0] OP_IN = 5'd5;
   localparam logic [4:0] OP_OUT = 5'd6;
   localparam logic [4:0] OP_RPUSH = 5'd7;
   localparam logic [4:0] OP_POP = 5'd8;
   localparam logic [4:0] OP_JMP = 5'd9;
   localparam logic [4:0] OP_JB = 5'd10;
   localparam logic [4:0] OP_JE = 5'd11;
   localparam logic [4:0] OP_JBE = 5'd12;
   localparam logic [4:0] OP_JA = 5'd13;
   localparam logic [4:0] OP_JAE = 5'd14;
   localparam logic [4:0] OP_JNE = 5'd15;
   localparam logic [4:0] OP_HALT = 5'd16;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_UNDER = 3'd1;
   localparam logic [2:0] ERR_OVER = 3'd2;
   localparam logic [2:0] ERR_DIV0 = 3'd3;
   localparam logic [2:0] ERR_OPCODE = 3'd4;
   localparam logic [2:0] ERR_REG = 3'd5;

   typedef struct packed {
      logic [4:0] action;
      logic signed [31:0] operand;
      logic signed [31:0] console_value;
   } req_type;

   typedef struct packed {
      logic [15:0] next_ip;
      logic out_valid;
      logic signed [31:0] out_value;
      logic halted;
      logic [2:0] error_code;
   } rsp_type;

endpackage

/* rtl/core/smeu_ram.sv */
module smeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/core/smeu_divider.sv */
module smeu_divider
   import smeu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [32:0] trial;
   logic [31:0] ma;
   logic [31:0] mb;

   assign ma = dividend[31] ? (32'd0 - dividend) : dividend;
   assign mb = divisor[31] ? (32'd0 - divisor) : divisor;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   // shift-subtract one quotient bit a cycle on magnitudes
   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 6'd0;
         rem_in = 32'd0;
         quo_in = ma;
         dvs_in = mb;
         neg_in = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            cnt_in = cnt_ff + 6'd1;
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
      end
   end

   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assert property (@(posedge clock) disable iff (reset) done |-> busy_ff)
      else $error("divider done while idle");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff <= 6'd32)
      else $error("divider count past width");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("divider did not start");

endmodule

/* rtl/core/stack_machine_execute_unit.sv */
// One instruction at a time: a new request is taken only in idle, after the last response is accepted.
// The stack memory's registered read port needs the read states RD1 (top entry) and RD2
// (second entry), and div waits in the DIV state for the bit-serial divider.
// Reset: synchronous, clears stack count, general registers, pointer and halt flag;
// stack contents stay undefined until pushed.
module stack_machine_execute_unit
   import smeu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_RD1   = 6'b000010,
      ST_RD2   = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] regs_ff [4];
   logic [31:0] regs_in [4];
   logic [15:0] ip_ff, ip_in;
   logic        halt_ff, halt_in;
   logic [31:0] top_ff, top_in;
   logic [31:0] below_ff, below_in;

   logic             wr_en;
   logic [SP_W-1:0]  wr_addr;
   logic [31:0]      wr_data;
   logic [SP_W-1:0]  rd_addr;
   logic [31:0]      rd_data;
   logic             div_start, div_done;
   logic [31:0]      div_q;

   // decode
   logic [1:0]  need_pop;
   logic        pushes, bad_op, bad_reg;
   logic [2:0]  err;
   logic        lt, eq, take;
   logic [31:0] alu;
   logic [15:0] nxt;
   logic [31:0] prod;

   smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   smeu_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(below_ff),
      .divisor(top_ff), .done(div_done), .quotient(div_q));

   always_comb begin
      need_pop = 2'd0;
      pushes = 1'b0;
      bad_op = 1'b0;
      bad_reg = (req_ff.operand > 32'sd3) || (req_ff.operand < 32'sd0);
      unique case (req_ff.action)
         OP_PUSH, OP_IN: pushes = 1'b1;
         OP_RPUSH: pushes = 1'b1;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JB, OP_JE, OP_JBE, OP_JA, OP_JAE,
         OP_JNE: need_pop = 2'd2;
         OP_OUT, OP_POP: need_pop = 2'd1;
         OP_JMP, OP_HALT: ;
         default: bad_op = 1'b1;
      endcase
      priority if (bad_op) err = ERR_OPCODE;
      else if (bad_reg && (req_ff.action == OP_RPUSH || req_ff.action == OP_POP))
         err = ERR_REG;
      else if (cnt_ff < CNT_W'(need_pop)) err = ERR_UNDER;
      else if (pushes && cnt_ff >= CNT_W'(STACK_DEPTH)) err = ERR_OVER;
      else if (req_ff.action == OP_DIV && top_ff == 32'd0) err = ERR_DIV0;
      else err = ERR_NONE;
   end

   assign lt = $signed(below_ff) < $signed(top_ff);
   assign eq = below_ff == top_ff;
   assign prod = below_ff * top_ff;

   always_comb begin
      unique case (req_ff.action)
         OP_JB: take = lt;
         OP_JE: take = eq;
         OP_JBE: take = lt || eq;
         OP_JA: take = !lt && !eq;
         OP_JAE: take = !lt;
         default: take = !eq;
      endcase
   end

   // sequence one instruction through read, execute and response
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      cnt_in = cnt_ff;
      regs_in = regs_ff;
      ip_in = ip_ff;
      halt_in = halt_ff;
      top_in = top_ff;
      below_in = below_ff;
      wr_en = 1'b0;
      wr_addr = cnt_ff[SP_W-1:0];
      wr_data = 32'd0;
      rd_addr = SP_W'(cnt_ff - CNT_W'(1));
      div_start = 1'b0;
      alu = 32'd0;
      nxt = ip_ff + 16'd1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = ST_RD1;
            end
         end
         // capture the top entry, read the second one
         ST_RD1: begin
            top_in = rd_data;
            rd_addr = SP_W'(cnt_ff - CNT_W'(2));
            state_in = ST_RD2;
         end
         ST_RD2: begin
            below_in = rd_data;
            state_in = ST_EXEC;
         end
         ST_EXEC, ST_DIV: begin
            rsp_in = '0;
            if (halt_ff) begin
               rsp_in.next_ip = ip_ff;
               rsp_in.halted = 1'b1;
               state_in = ST_RESP;
            end else if (state_ff == ST_EXEC && req_ff.action == OP_DIV &&
                         err == ERR_NONE) begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end else if (state_ff == ST_DIV && !div_done) begin
               state_in = ST_DIV;
            end else if (err != ERR_NONE) begin
               rsp_in.next_ip = ip_ff;
               rsp_in.halted = 1'b1;
               rsp_in.error_code = err;
               halt_in = 1'b1;
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff - CNT_W'(need_pop);
               wr_addr = SP_W'(cnt_in);
               unique case (req_ff.action)
                  OP_PUSH: begin alu = req_ff.operand; nxt = ip_ff + 16'd2; end
                  OP_ADD: alu = below_ff + top_ff;
                  OP_SUB: alu = below_ff - top_ff;
                  OP_MUL: alu = prod;
                  OP_DIV: alu = div_q;
                  OP_IN: alu = req_ff.console_value;
                  OP_RPUSH: begin
                     alu = regs_ff[req_ff.operand[1:0]];
                     nxt = ip_ff + 16'd2;
                  end
                  OP_POP: begin
                     regs_in[req_ff.operand[1:0]] = top_ff;
                     nxt = ip_ff + 16'd2;
                  end
                  OP_OUT: begin
                     rsp_in.out_valid = 1'b1;
                     rsp_in.out_value = top_ff;
                  end
                  OP_JMP: nxt = req_ff.operand[15:0];
                  OP_HALT: begin halt_in = 1'b1; nxt = ip_ff; end
                  default: nxt = take ? req_ff.operand[15:0] : ip_ff + 16'd2;
               endcase
               if (pushes || req_ff.action == OP_ADD || req_ff.action == OP_SUB ||
                   req_ff.action == OP_MUL || req_ff.action == OP_DIV) begin
                  wr_en = 1'b1;
                  wr_data = alu;
                  cnt_in = cnt_ff - CNT_W'(need_pop) + CNT_W'(1);
               end
               ip_in = nxt;
               rsp_in.next_ip = nxt;
               rsp_in.halted = halt_in;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_RESP;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         ip_ff <= 16'd0;
         halt_ff <= 1'b0;
         for (int i = 0; i < 4; i++) regs_ff[i] <= 32'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ip_ff <= ip_in;
         halt_ff <= halt_in;
         regs_ff <= regs_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      top_ff <= top_in;
      below_ff <= below_in;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count past depth");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE |-> rsp_data.halted)
      else $error("error without halt");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_valid |-> !rsp_data.halted)
      else $error("output while halted");

endmodule
